/* hw/rtl/llrp_pkg.sv */
// shared types and constants of the least-loaded row partition unit
// no dependencies

package llrp_pkg;

   localparam int LLRP_MAX_ROWS = 16;

   localparam int ROW_W   = 24;
   localparam int ITEM_W  = 12;
   localparam int PAD_W   = 9;
   localparam int RCNT_W  = 5;
   localparam int RIDX_W  = 4;
   localparam int CSR_W   = 9;

   localparam logic [ROW_W-1:0] ROW_SAT = {ROW_W{1'b1}};

   // configuration register indexes
   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_PAD_WIDTH = 1'b1;

   typedef enum logic [1:0] {
      IDLE_ST,
      SCAN_ST,
      UPD_ST
   } state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic             upd;
      logic             clr;
      logic [ROW_W-1:0] upd_width;
      logic [PAD_W-1:0] pad;
   } cell_ctl_type;

endpackage

/* hw/rtl/llrp_cell.sv */
// one row cell: holds one running row width and one stage of the min-search chain
// depends on llrp_pkg

module llrp_cell
   import llrp_pkg::*;
#(
   parameter int MAX_ROWS = LLRP_MAX_ROWS,
   parameter int IDX      = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctl_type                  ctl,
   input  logic [$clog2(MAX_ROWS)-1:0]   upd_idx,
   input  logic [$clog2(MAX_ROWS+1)-1:0] rows_n,
   input  logic [ROW_W-1:0]              cand_w_i,
   input  logic [$clog2(MAX_ROWS)-1:0]   cand_idx_i,
   output logic [ROW_W-1:0]              cand_w_o,
   output logic [$clog2(MAX_ROWS)-1:0]   cand_idx_o
);

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

   logic [ROW_W-1:0] width_ff, width_in;
   logic [ROW_W-1:0] cand_w_ff, cand_w_in;
   logic [IDX_W-1:0] cand_idx_ff, cand_idx_in;
   logic             take_own;

   // strict compare keeps the lower row on a tie
   always_comb begin
      take_own = (IDX == 0) || ((MY_POS < rows_n) && (width_ff < cand_w_i));
      cand_w_in   = take_own ? width_ff : cand_w_i;
      cand_idx_in = take_own ? MY_IDX : cand_idx_i;
   end

   always_comb begin
      if (ctl.clr) begin
         width_in = ROW_W'(ctl.pad);
      end else if (ctl.upd && (upd_idx == MY_IDX)) begin
         width_in = ctl.upd_width;
      end else begin
         width_in = width_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
      end else begin
         width_ff <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_w_ff   <= cand_w_in;
      cand_idx_ff <= cand_idx_in;
   end

   assign cand_w_o   = cand_w_ff;
   assign cand_idx_o = cand_idx_ff;

endmodule

/* hw/rtl/least_loaded_row_partition_unit.sv */
// top level of the least-loaded row partition unit: sequencer, config and cell chain
// depends on llrp_pkg and llrp_cell
//
// usage:
//  - req_ channel: one beat per item, item width in req_tdata[11:0], req_tlast marks
//    the last item of a run
//  - rsp_ channel: one beat per item, chosen row in rsp_tdata[3:0], largest row width
//    so far in rsp_tdata[27:4], rsp_tlast closes the run
//  - csr_ port: row count (index 0) and pad width (index 1), written while idle;
//    each write starts a new run, rows are cleared on the following cycle
// sequence:
//  - the min search walks the row cells one per cycle; the result beat is
//    registered in the update that ends the search
//  - one item at a time: accept, a search step per row cell, update
// reset: one row in use, zero padding, all rows and the maximum at zero
// stall: a waiting result beat is held in the output register; the next item
//  may still be taken and searched, its update waits until the beat leaves
// after the last item of a run the rows return to the pad width in the same update

module least_loaded_row_partition_unit
   import llrp_pkg::*;
#(
   parameter int MAX_ROWS = LLRP_MAX_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   // slave side
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [11:0] item_width, [15:12] zero
   input  logic              req_tlast,   // last_item
   // master side
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [3:0] row_index, [27:4] max_row_width
   output logic              rsp_tlast,   // run_done
   // configuration
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam int RC_W  = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;
   localparam int SUM_W = ROW_W + 2;

   state_type state_ff, state_in;

   // configuration
   logic [RCNT_W-1:0] row_count_ff, row_count_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic              clr_pend_ff, clr_pend_in;
   logic [CNT_W-1:0]  rows_n;
   logic [RC_W-1:0]   rc_ext;

   // item in flight
   logic [ITEM_W-1:0] item_ff, item_in;
   logic              last_ff, last_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;

   // result path
   logic [ROW_W-1:0]  run_max_ff, run_max_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RIDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [ROW_W-1:0]  rsp_max_ff, rsp_max_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              upd_go;
   logic              scan_done;
   logic [SUM_W-1:0]  sum;
   logic [ROW_W-1:0]  grown;
   logic [ROW_W-1:0]  new_max;
   logic [ROW_W-1:0]  best_w;
   logic [IDX_W-1:0]  best_idx;
   cell_ctl_type      ctl;

   // search chain
   logic [ROW_W-1:0]  cw [MAX_ROWS];
   logic [IDX_W-1:0]  ci [MAX_ROWS];

   // rows in use: zero means one, anything above the chain length is clamped
   always_comb begin
      rc_ext = RC_W'(row_count_ff);
      if (rc_ext == '0) begin
         rows_n = CNT_W'(1);
      end else if (rc_ext > RC_W'(MAX_ROWS)) begin
         rows_n = CNT_W'(MAX_ROWS);
      end else begin
         rows_n = CNT_W'(rc_ext);
      end
   end

   assign best_w   = cw[MAX_ROWS-1];
   assign best_idx = ci[MAX_ROWS-1];

   assign accept    = req_tvalid && req_tready;
   assign upd_go    = (state_ff == UPD_ST) && (!rsp_valid_ff || rsp_tready);
   assign scan_done = (scan_cnt_ff == CNT_W'(MAX_ROWS - 1));

   // chosen row grows by item plus padding, saturating
   always_comb begin
      sum     = SUM_W'(best_w) + SUM_W'(item_ff) + SUM_W'(pad_ff);
      grown   = (sum > SUM_W'(ROW_SAT)) ? ROW_SAT : sum[ROW_W-1:0];
      new_max = (grown > run_max_ff) ? grown : run_max_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE_ST: begin
            if (accept) begin
               state_in = SCAN_ST;
            end
         end
         SCAN_ST: begin
            if (scan_done) begin
               state_in = UPD_ST;
            end
         end
         UPD_ST: begin
            if (upd_go) begin
               state_in = IDLE_ST;
            end
         end
         default: state_in = IDLE_ST;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      scan_cnt_in   = scan_cnt_ff;
      item_in       = item_ff;
      last_in       = last_ff;
      ctl.upd       = 1'b0;
      ctl.clr       = clr_pend_ff;
      ctl.upd_width = grown;
      ctl.pad       = pad_ff;
      unique case (state_ff)
         IDLE_ST: begin
            req_tready  = !clr_pend_ff;
            scan_cnt_in = '0;
            if (accept) begin
               item_in = req_tdata[ITEM_W-1:0];
               last_in = req_tlast;
            end
         end
         SCAN_ST: begin
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
         end
         UPD_ST: begin
            ctl.upd = upd_go;
            ctl.clr = clr_pend_ff || (upd_go && last_ff);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // configuration writes; rows clear on the next cycle
   always_comb begin
      row_count_in = row_count_ff;
      pad_in       = pad_ff;
      clr_pend_in  = 1'b0;
      if (csr_we) begin
         clr_pend_in = 1'b1;
         unique case (csr_index)
            REG_ROW_COUNT: row_count_in = csr_wdata[RCNT_W-1:0];
            REG_PAD_WIDTH: pad_in       = csr_wdata[PAD_W-1:0];
            default:       clr_pend_in  = 1'b1;
         endcase
      end
   end

   // running maximum and output register
   always_comb begin
      run_max_in   = run_max_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (upd_go) begin
         run_max_in   = new_max;
         rsp_valid_in = 1'b1;
         rsp_idx_in   = RIDX_W'(best_idx);
         rsp_max_in   = new_max;
         rsp_last_in  = last_ff;
      end
      if (ctl.clr) begin
         run_max_in = ROW_W'(pad_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         row_count_ff <= RCNT_W'(1);
         pad_ff       <= '0;
         clr_pend_ff  <= 1'b0;
         run_max_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         scan_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         pad_ff       <= pad_in;
         clr_pend_ff  <= clr_pend_in;
         run_max_ff   <= run_max_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_cnt_ff  <= scan_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      last_ff     <= last_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_max_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // row cells: each passes the best (width, row) so far to its right neighbor
   for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
      if (g == 0) begin : g_head
         llrp_cell #(
            .MAX_ROWS (MAX_ROWS),
            .IDX      (g)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .upd_idx    (best_idx),
            .rows_n     (rows_n),
            .cand_w_i   ('0),
            .cand_idx_i ('0),
            .cand_w_o   (cw[g]),
            .cand_idx_o (ci[g])
         );
      end else begin : g_body
         llrp_cell #(
            .MAX_ROWS (MAX_ROWS),
            .IDX      (g)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .upd_idx    (best_idx),
            .rows_n     (rows_n),
            .cand_w_i   (cw[g-1]),
            .cand_idx_i (ci[g-1]),
            .cand_w_o   (cw[g]),
            .cand_idx_o (ci[g])
         );
      end
   end

   // the chain never picks a row outside the rows in use
   a_best_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPD_ST) |-> (CNT_W'(best_idx) < rows_n))
      else $error("chosen row outside rows in use");

   // a result beat only starts from an update
   a_rsp_from_upd: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == UPD_ST))
      else $error("result beat without update");

   // closing a run brings the maximum back to the padding
   a_run_restart: assert property (@(posedge clock) disable iff (reset)
      (upd_go && last_ff && !csr_we) |=> (run_max_ff == ROW_W'(pad_ff)))
      else $error("running maximum not restarted");

   // no item is taken while a clear is pending
   a_no_accept_clr: assert property (@(posedge clock) disable iff (reset)
      clr_pend_ff |-> !req_tready)
      else $error("item accepted during row clear");

endmodule

/* sim/least_loaded_row_partition_unit_tb.sv */
// testbench of least_loaded_row_partition_unit: directed and random item streams,
// checked beat by beat against an in-bench greedy row placement model
// depends on llrp_pkg and the unit's rtl

`timescale 1ns / 100ps

module least_loaded_row_partition_unit_tb;
   import llrp_pkg::*;

   localparam int          ROWS_TB      = LLRP_MAX_ROWS;
   localparam int unsigned RANDOM_ITEMS = 1850;
   localparam int unsigned SETTLE       = ROWS_TB + 4;
   localparam longint unsigned CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [RIDX_W-1:0] row;
      logic [ROW_W-1:0]  peak;
      logic              done;
   } placement_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [15:0]       req_tdata;   // [11:0] item_width, [15:12] zero
   logic              req_tlast;   // last_item
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;   // [3:0] row_index, [27:4] max_row_width
   logic              rsp_tlast;   // run_done
   logic              csr_we;
   logic              csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   // prediction state: loads of all rows, the largest load, the two registers
   logic [ROW_W-1:0]  row_load [ROWS_TB];
   logic [ROW_W-1:0]  peak_load;
   logic [RCNT_W-1:0] cfg_rows;
   logic [PAD_W-1:0]  cfg_pad;

   placement_type     pending_placements [$];

   int unsigned       err_count;
   int unsigned       items_sent;
   int unsigned       results_seen;
   int unsigned       runs_closed;
   int unsigned       csr_writes;
   longint unsigned   cycle_count;
   bit                calm;          // no gaps and no stalls while set
   int unsigned       stall_left;

   least_loaded_row_partition_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // placement model
   // ---------------------------------------------------------------------

   // all rows back to the pad width, a fresh run
   function automatic void restart_loads();
      for (int i = 0; i < ROWS_TB; i++)
         row_load[i] = {{(ROW_W-PAD_W){1'b0}}, cfg_pad};
      peak_load = {{(ROW_W-PAD_W){1'b0}}, cfg_pad};
   endfunction

   function automatic void apply_csr(input logic idx, input logic [CSR_W-1:0] val);
      if (idx == REG_ROW_COUNT)
         cfg_rows = val[RCNT_W-1:0];
      else
         cfg_pad = val[PAD_W-1:0];
      restart_loads();
   endfunction

   // greedy choice of the least loaded row, lowest index on ties
   function automatic void place_item(input logic [ITEM_W-1:0] w, input logic last);
      int            n;
      int            best;
      logic [ROW_W:0] grown;
      placement_type p;
      // row count zero acts as one row, above the row limit it saturates
      if (cfg_rows == '0)
         n = 1;
      else if (int'(cfg_rows) > ROWS_TB)
         n = ROWS_TB;
      else
         n = int'(cfg_rows);
      best = 0;
      for (int i = 1; i < n; i++)
         if (row_load[i] < row_load[best])
            best = i;
      grown = {1'b0, row_load[best]} + (ROW_W+1)'(w) + (ROW_W+1)'(cfg_pad);
      if (grown > {1'b0, ROW_SAT})
         grown = {1'b0, ROW_SAT};
      row_load[best] = grown[ROW_W-1:0];
      if (grown[ROW_W-1:0] > peak_load)
         peak_load = grown[ROW_W-1:0];
      p.row  = best[RIDX_W-1:0];
      p.peak = peak_load;
      p.done = last;
      pending_placements = {pending_placements, p};
      if (last)
         restart_loads();
   endfunction

   // ---------------------------------------------------------------------
   // monitors: predict on every accepted request beat, check every result beat
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         place_item(req_tdata[ITEM_W-1:0], req_tlast);
   end

   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_placements.size() == 0) begin
            $error("result beat with no placement pending");
            err_count++;
         end else begin
            want = pending_placements.pop_front();
            if (rsp_tdata[RIDX_W-1:0] !== want.row) begin
               $error("row_index: expected %0d, got %0d", want.row, rsp_tdata[RIDX_W-1:0]);
               err_count++;
            end
            if (rsp_tdata[RIDX_W +: ROW_W] !== want.peak) begin
               $error("max_row_width: expected %0d, got %0d",
                      want.peak, rsp_tdata[RIDX_W +: ROW_W]);
               err_count++;
            end
            if (rsp_tlast !== want.done) begin
               $error("run_done: expected %0d, got %0d", want.done, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("least_loaded_row_partition_unit_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // idling on both sides
   // ---------------------------------------------------------------------

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers, all called at a falling edge
   // ---------------------------------------------------------------------

   // one request beat; valid stays high into the next beat when no gap follows
   task automatic send_item(input logic [ITEM_W-1:0] w, input logic last);
      int unsigned gap;
      req_tdata  = {{(16-ITEM_W){1'b0}}, w};
      req_tlast  = last;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (last)
         runs_closed++;
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // sender holds off until every pending result beat is back
   task automatic wait_results_done();
      req_tvalid = 1'b0;
      while (pending_placements.size() != 0)
         @(negedge clock);
   endtask

   // register write only with the unit idle, then let the row clear settle
   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] val);
      wait_results_done();
      repeat (SETTLE) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      apply_csr(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_we = 1'b0;
      repeat (2) @(negedge clock);
   endtask

   function automatic logic [ITEM_W-1:0] rand_width();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return {ITEM_W{1'b1}};
      if (r < 5)
         return ITEM_W'($urandom_range(0, 15));   // small widths make ties frequent
      return ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
   endfunction

   function automatic logic [CSR_W-1:0] rand_rows();
      logic [CSR_W-1:0] v;
      v = CSR_W'($urandom_range(0, (1 << CSR_W) - 1));
      // half of the time a row count in range, upper bits still random
      if ($urandom_range(0, 1))
         v[RCNT_W-1:0] = RCNT_W'($urandom_range(1, ROWS_TB));
      return v;
   endfunction

   function automatic logic [CSR_W-1:0] rand_pad();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return '0;
      if (r == 1)
         return {CSR_W{1'b1}};
      return CSR_W'($urandom_range(0, (1 << CSR_W) - 1));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset settings: one row, no padding
   task automatic test_reset_defaults();
      send_item('0, 1'b0);
      send_item({ITEM_W{1'b1}}, 1'b0);
      send_item(12'd1, 1'b1);
      send_item(12'd7, 1'b1);
   endtask

   // row count zero, full row count, row count above the limit, pad extremes, ties
   task automatic test_row_count_limits();
      write_csr(REG_ROW_COUNT, 9'h1E0);   // low bits zero: one row
      send_item(12'd5, 1'b0);
      send_item(12'd7, 1'b1);
      write_csr(REG_ROW_COUNT, 9'h010);   // all sixteen rows
      write_csr(REG_PAD_WIDTH, 9'h1FF);
      send_item('0, 1'b0);                // equal loads: lowest rows first
      send_item('0, 1'b0);
      send_item('0, 1'b0);
      send_item({ITEM_W{1'b1}}, 1'b0);
      send_item('0, 1'b1);
      write_csr(REG_ROW_COUNT, 9'h1FF);   // 31 rows asked, sixteen used
      send_item(12'd100, 1'b0);
      send_item(12'd3, 1'b1);
      write_csr(REG_PAD_WIDTH, 9'h000);
      send_item({ITEM_W{1'b1}}, 1'b0);
      send_item('0, 1'b1);
   endtask

   // a register write in the middle of a run starts a new one
   task automatic test_write_mid_run();
      write_csr(REG_ROW_COUNT, 9'h003);
      write_csr(REG_PAD_WIDTH, 9'h0AA);
      send_item(12'd10, 1'b0);
      send_item(12'd20, 1'b0);
      send_item(12'd30, 1'b0);
      write_csr(REG_PAD_WIDTH, 9'h155);
      send_item(12'd1, 1'b0);
      send_item(12'd2, 1'b0);
      write_csr(REG_ROW_COUNT, 9'h002);
      send_item(12'd9, 1'b1);
   endtask

   // random settings, random run lengths, random widths
   task automatic test_random_runs();
      int unsigned sent;
      int unsigned phase_len;
      int unsigned run_len;
      int unsigned k;
      bit          close_run;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1)) begin
            write_csr(REG_ROW_COUNT, rand_rows());
            write_csr(REG_PAD_WIDTH, rand_pad());
         end else begin
            write_csr(REG_PAD_WIDTH, rand_pad());
            write_csr(REG_ROW_COUNT, rand_rows());
         end
         phase_len = $urandom_range(60, 200);
         k = 0;
         while (k < phase_len) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 20);
            // some runs are left open and merge into the next or get cut by a write
            close_run = ($urandom_range(0, 7) != 0);
            for (int unsigned j = 0; j < run_len; j++)
               send_item(rand_width(), close_run && (j == run_len - 1));
            k += run_len;
            if ($urandom_range(0, 15) == 0)
               wait_results_done();
         end
         sent += k;
      end
      calm = 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = REG_ROW_COUNT;
      csr_wdata   = '0;
      err_count   = 0;
      items_sent  = 0;
      results_seen = 0;
      runs_closed = 0;
      csr_writes  = 0;
      cycle_count = 0;
      calm        = 1'b0;
      stall_left  = 0;
      cfg_rows    = 5'd1;
      cfg_pad     = '0;
      restart_loads();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_row_count_limits();
      test_write_mid_run();
      test_random_runs();

      wait_results_done();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d items in %0d closed runs over %0d register writes,",
               items_sent, runs_closed, csr_writes);
      $display("with row count and pad extremes, ties and open runs; %0d beats checked",
               results_seen);
      if (err_count == 0 && pending_placements.size() == 0) begin
         $display("least_loaded_row_partition_unit_tb: clean");
      end else begin
         $display("least_loaded_row_partition_unit_tb: errors");
      end
      $finish;
   end

endmodule
